FILE: hdl/rtic_pkg.sv
package rtic_pkg;

  typedef enum logic [2:0] {
    KIND_NUL,
    KIND_PLUS,
    KIND_MINUS,
    KIND_DIGIT,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] digit;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        minus;
    logic        digit_seen;
    logic [2:0]  err;
  } snap_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd1;
  localparam logic [2:0] ST_BASE      = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [2:0] MODE_RAW = 3'd0;
  localparam logic [2:0] MODE_S64 = 3'd1;
  localparam logic [2:0] MODE_U64 = 3'd2;
  localparam logic [2:0] MODE_S32 = 3'd3;
  localparam logic [2:0] MODE_U32 = 3'd4;

  localparam logic REG_RADIX = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd10;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;

  localparam logic [63:0] LOW32_MASK = 64'h00000000ffffffff;

endpackage

FILE: hdl/rtic_front.sv
module rtic_front
  import rtic_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output char_item_t head,
  output logic       head_valid,
  input  logic       head_ready
);

  localparam int DEPTH = 2;

  char_item_t item_in;
  char_item_t q [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // character classification
  always_comb begin
    item_in.kind  = KIND_BAD;
    item_in.digit = 6'd0;
    item_in.last  = last;
    if (ch == CH_NUL) begin
      item_in.kind = KIND_NUL;
    end else if (ch == CH_MINUS) begin
      item_in.kind = KIND_MINUS;
    end else if (ch == CH_PLUS) begin
      item_in.kind = KIND_PLUS;
    end else if (ch >= CH_0 && ch <= CH_9) begin
      item_in.kind  = KIND_DIGIT;
      item_in.digit = 6'(ch - CH_0);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      item_in.kind  = KIND_DIGIT;
      item_in.digit = 6'(ch - CH_LOWER_A) + 6'd10;
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      item_in.kind  = KIND_DIGIT;
      item_in.digit = 6'(ch - CH_UPPER_A) + 6'd10;
    end
  end

  assign in_ready   = (count != 2'(DEPTH));
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/rtic_back.sv
module rtic_back
  import rtic_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  char_item_t head,
  input  logic       head_valid,
  output logic       head_ready,
  input  logic [5:0] radix,
  output snap_t      snap,
  output logic       snap_valid,
  input  logic       snap_ready
);

  logic [63:0] acc;
  logic        at_first;
  logic        minus;
  logic        digit_seen;
  logic [2:0]  err;
  logic        terminated;

  logic [63:0] acc_next;
  logic        at_first_next;
  logic        minus_next;
  logic        digit_seen_next;
  logic [2:0]  err_next;
  logic        terminated_next;

  logic [69:0] sum;
  logic        ovf;
  logic        take;

  assign sum  = 70'(acc) * 70'(radix) + 70'(head.digit);
  assign ovf  = |sum[69:64];
  assign head_ready = !head.last || !snap_valid || snap_ready;
  assign take = head_valid && head_ready;

  always_comb begin
    acc_next        = acc;
    at_first_next   = at_first;
    minus_next      = minus;
    digit_seen_next = digit_seen;
    err_next        = err;
    terminated_next = terminated;
    if (!terminated) begin
      at_first_next = 1'b0;
      if (head.kind == KIND_NUL) begin
        terminated_next = 1'b1;
      end else if (at_first && (head.kind == KIND_MINUS || head.kind == KIND_PLUS)) begin
        minus_next = (head.kind == KIND_MINUS);
      end else if (err == ST_OK) begin
        if (head.kind != KIND_DIGIT) begin
          err_next = ST_BAD_DIGIT;
        end else begin
          digit_seen_next = 1'b1;
          if (head.digit >= radix) begin
            err_next = ST_BASE;
          end else if (ovf) begin
            err_next = ST_OVERFLOW;
          end else begin
            acc_next = sum[63:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= 64'd0;
      at_first   <= 1'b1;
      minus      <= 1'b0;
      digit_seen <= 1'b0;
      err        <= ST_OK;
      terminated <= 1'b0;
      snap_valid <= 1'b0;
    end else begin
      if (take) begin
        if (head.last) begin
          acc        <= 64'd0;
          at_first   <= 1'b1;
          minus      <= 1'b0;
          digit_seen <= 1'b0;
          err        <= ST_OK;
          terminated <= 1'b0;
        end else begin
          acc        <= acc_next;
          at_first   <= at_first_next;
          minus      <= minus_next;
          digit_seen <= digit_seen_next;
          err        <= err_next;
          terminated <= terminated_next;
        end
      end
      if (take && head.last) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

  // string state as it stands after the final item
  always_ff @(posedge clk) begin
    if (take && head.last) begin
      snap.acc        <= acc_next;
      snap.minus      <= minus_next;
      snap.digit_seen <= digit_seen_next;
      snap.err        <= err_next;
    end
  end

endmodule

FILE: hdl/rtic_result.sv
module rtic_result
  import rtic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  snap_t       snap,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  logic [5:0]  radix,
  input  logic [2:0]  result_mode,
  output logic [63:0] value,
  output logic        negative,
  output logic [2:0]  status,
  output logic        out_valid,
  input  logic        out_ready
);

  logic [2:0]  st;
  logic [63:0] v;
  logic [63:0] neg_acc;
  logic        hi_zero;
  logic        load;

  assign snap_ready = !out_valid || out_ready;
  assign load       = snap_valid && snap_ready;
  assign neg_acc    = 64'd0 - snap.acc;
  assign hi_zero    = (snap.acc[63:32] == 32'd0);

  always_comb begin
    st = snap.err;
    v  = 64'd0;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      st = ST_BASE;
    end else if (st == ST_OK && !snap.digit_seen) begin
      st = ST_EMPTY;
    end
    if (st == ST_OK) begin
      case (result_mode)
        MODE_S64: begin
          if (snap.minus ? (snap.acc[63] && snap.acc[62:0] != 63'd0) : snap.acc[63]) begin
            st = ST_OVERFLOW;
          end else begin
            v = snap.minus ? neg_acc : snap.acc;
          end
        end
        MODE_S32: begin
          if (!hi_zero || (snap.minus ? (snap.acc[31] && snap.acc[30:0] != 31'd0)
                                      : snap.acc[31])) begin
            st = ST_OVERFLOW;
          end else begin
            v = snap.minus ? neg_acc : snap.acc;
          end
        end
        MODE_U64: begin
          if (snap.minus) begin
            st = ST_BAD_DIGIT;
          end else begin
            v = snap.acc;
          end
        end
        MODE_U32: begin
          if (snap.minus) begin
            st = ST_BAD_DIGIT;
          end else if (snap.acc > LOW32_MASK) begin
            st = ST_OVERFLOW;
          end else begin
            v = snap.acc;
          end
        end
        default: begin
          v = snap.minus ? neg_acc : snap.acc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value    <= v;
      negative <= snap.minus;
      status   <= st;
    end
  end

endmodule

FILE: hdl/radix_text_to_integer_checked_unit.sv
// Throughput: one character item per cycle, unless an output stall holds back a final item;
// the accumulate step (64 x 6 multiply-add) handles one item each cycle.
// A result is registered in turn by the queue, the string state and the range check
// after the edge that accepts its final item, and can be held by any output stall.
// Reset clears the queue, string state and output; radix returns to 10, result_mode to 0.
module radix_text_to_integer_checked_unit
  import rtic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic        negative,
  output logic [2:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  logic [5:0] radix;
  logic [2:0] result_mode;

  char_item_t head;
  logic       head_valid;
  logic       head_ready;
  snap_t      snap;
  logic       snap_valid;
  logic       snap_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      result_mode <= MODE_RAW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX: radix       <= cfg_data;
        REG_MODE:  result_mode <= cfg_data[2:0];
        default:   radix       <= radix;
      endcase
    end
  end

  rtic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .last       (last),
    .head       (head),
    .head_valid (head_valid),
    .head_ready (head_ready)
  );

  rtic_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .radix      (radix),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  rtic_result u_result (
    .clk         (clk),
    .rst         (rst),
    .snap        (snap),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .radix       (radix),
    .result_mode (result_mode),
    .value       (value),
    .negative    (negative),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule
